>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes, command codes and ring helpers for the deque block.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Storage geometry
  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the beats
  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Command codes; unused codes behave as a query
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic                      underflow;
    logic                      overflow;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
  } deq_out_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_LOAD
  } deq_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic fill;
    logic load_out;
  } deq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } deq_stat_t;

  function automatic idx_t ring_next(idx_t i);
    idx_t r;
    if (i == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  function automatic idx_t ring_prev(idx_t i);
    idx_t r;
    if (i == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = i - 1'b1;
    end
    return r;
  endfunction

  // Keep the low stored bits of an incoming value
  function automatic data_t value_to_data(logic [VALUE_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  // Present stored bits on a 32-bit field
  function automatic logic [VALUE_W-1:0] data_to_value(data_t d);
    logic [63:0] w;
    w = 64'(d);
    return w[VALUE_W-1:0];
  endfunction

endpackage

>>> rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: take a command beat, execute, refill cached ends, load result.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_cmd_t  cmd
);

  deq_pkg::deq_state_t state_r;
  deq_pkg::deq_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = deq_pkg::ST_EXEC;
        end
      end
      deq_pkg::ST_EXEC: state_nxt = deq_pkg::ST_FILL;
      deq_pkg::ST_FILL: state_nxt = deq_pkg::ST_LOAD;
      deq_pkg::ST_LOAD: begin
        if (stat.out_free) begin
          state_nxt = deq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = deq_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      deq_pkg::ST_EXEC: cmd.exec = 1'b1;
      deq_pkg::ST_FILL: cmd.fill = 1'b1;
      deq_pkg::ST_LOAD: cmd.load_out = stat.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: ring pointers, entry count, cached front/back, entry RAM and
// the output register.
// ----------------------------------------------------------------------------
module deq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::deq_in_t   in_data,
  input  deq_pkg::deq_cmd_t  cmd,
  output deq_pkg::deq_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::deq_out_t  out_data
);

  // Latched command
  logic [deq_pkg::MODE_W-1:0] mode_r;
  deq_pkg::data_t             value_r;

  // Ring state
  deq_pkg::idx_t  head_r, head_nxt;
  deq_pkg::idx_t  tail_r, tail_nxt;
  deq_pkg::cnt_t  count_r, count_nxt;
  deq_pkg::data_t front_r, front_nxt;
  deq_pkg::data_t back_r, back_nxt;

  // Per-command results
  deq_pkg::data_t popped_r, popped_nxt;
  logic           under_r, under_nxt;
  logic           over_r, over_nxt;
  logic           fill_front_r, fill_front_nxt;
  logic           fill_back_r, fill_back_nxt;

  // Output register
  logic              out_valid_r;
  deq_pkg::deq_out_t out_data_r;
  deq_pkg::deq_out_t result;

  // RAM ports
  logic           wr_en;
  deq_pkg::idx_t  wr_addr;
  deq_pkg::idx_t  rd_addr;
  deq_pkg::data_t rd_data;

  logic is_full;
  logic is_empty;

  assign is_full  = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign is_empty = (count_r == '0);

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode_r  <= in_data.mode;
      value_r <= deq_pkg::value_to_data(in_data.push_value);
    end
  end

  // Execute the command and refill the cached ends
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    popped_nxt     = popped_r;
    under_nxt      = under_r;
    over_nxt       = over_r;
    fill_front_nxt = fill_front_r;
    fill_back_nxt  = fill_back_r;
    wr_en          = 1'b0;
    wr_addr        = tail_r;
    rd_addr        = deq_pkg::ring_next(head_r);
    if (cmd.exec) begin
      popped_nxt     = '0;
      under_nxt      = 1'b0;
      over_nxt       = 1'b0;
      fill_front_nxt = 1'b0;
      fill_back_nxt  = 1'b0;
      case (mode_r)
        deq_pkg::MODE_PUSH_FRONT: begin
          if (is_full) begin
            over_nxt = 1'b1;
          end else begin
            head_nxt  = deq_pkg::ring_prev(head_r);
            wr_en     = 1'b1;
            wr_addr   = deq_pkg::ring_prev(head_r);
            count_nxt = count_r + 1'b1;
            front_nxt = value_r;
            if (is_empty) begin
              back_nxt = value_r;
            end
          end
        end
        deq_pkg::MODE_PUSH_BACK: begin
          if (is_full) begin
            over_nxt = 1'b1;
          end else begin
            tail_nxt  = deq_pkg::ring_next(tail_r);
            wr_en     = 1'b1;
            wr_addr   = tail_r;
            count_nxt = count_r + 1'b1;
            back_nxt  = value_r;
            if (is_empty) begin
              front_nxt = value_r;
            end
          end
        end
        deq_pkg::MODE_POP_FRONT: begin
          if (is_empty) begin
            under_nxt = 1'b1;
          end else begin
            popped_nxt     = front_r;
            head_nxt       = deq_pkg::ring_next(head_r);
            count_nxt      = count_r - 1'b1;
            fill_front_nxt = 1'b1;
            rd_addr        = deq_pkg::ring_next(head_r);
          end
        end
        deq_pkg::MODE_POP_BACK: begin
          if (is_empty) begin
            under_nxt = 1'b1;
          end else begin
            popped_nxt    = back_r;
            tail_nxt      = deq_pkg::ring_prev(tail_r);
            count_nxt     = count_r - 1'b1;
            fill_back_nxt = 1'b1;
            rd_addr       = deq_pkg::ring_prev(deq_pkg::ring_prev(tail_r));
          end
        end
        default: begin
          under_nxt = 1'b0;
        end
      endcase
    end
    if (cmd.fill) begin
      if (fill_front_r) begin
        front_nxt = rd_data;
      end
      if (fill_back_r) begin
        back_nxt = rd_data;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      fill_front_r <= 1'b0;
      fill_back_r  <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      fill_front_r <= fill_front_nxt;
      fill_back_r  <= fill_back_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    front_r  <= front_nxt;
    back_r   <= back_nxt;
    popped_r <= popped_nxt;
    under_r  <= under_nxt;
    over_r   <= over_nxt;
  end

  // Entry store
  deq_ram #(
    .WIDTH (deq_pkg::DATA_WIDTH),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_r),
    .rd_en   (cmd.exec),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Assemble the result beat
  always_comb begin
    result.popped_value = deq_pkg::data_to_value(popped_r);
    result.underflow    = under_r;
    result.overflow     = over_r;
    result.entry_count  = deq_pkg::COUNT_W'(count_r);
    result.is_empty     = is_empty;
    result.front_value  = is_empty ? '0 : deq_pkg::data_to_value(front_r);
    result.back_value   = is_empty ? '0 : deq_pkg::data_to_value(back_r);
  end

  // Output register: load when free, drop the beat once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= result;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == tail_r)
    else $error("empty deque with head and tail apart");

  a_one_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !(fill_front_r && fill_back_r))
    else $error("both ends marked for refill");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken beat");
`endif

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque in a ring of entries with push/pop at either end.
// Commands pass through EXEC, FILL and LOAD, which waits for a free output
// register; a new one is taken only in IDLE. FILL covers the RAM's registered
// read that refills the cached front or back entry after a pop.
// Reset (rst_n, synchronous): deque empty, pointers and count zero.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output deq_pkg::deq_out_t out_data
);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;

  // Sequencer
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result path
  deq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives deque commands through the valid/ready input channel and predicts
// every result beat with a cycle-free software deque. The run covers:
//   - pops and queries on an empty deque, and the spare command codes;
//   - one to three entries carrying extreme values;
//   - a fill to full depth, pushes dropped on a full deque, and a partial drain;
//   - random traffic.
// Sender bursts and receiver stalls move the gaps across the block's phases.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Spare command codes, expected to act as a query
  localparam logic [deq_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [deq_pkg::MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int SETTLE_TICKS = 12;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  deq_pkg::deq_in_t   in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  deq_pkg::deq_out_t  out_data;

  double_ended_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow deque and the result beats it has promised
  deq_pkg::data_t    deque_words [deq_pkg::DEPTH];
  deq_pkg::idx_t     head_slot = '0;
  deq_pkg::idx_t     tail_slot = '0;
  int                word_count = 0;
  deq_pkg::deq_out_t awaited_results [$];

  // Run statistics
  int commands_sent  = 0;
  int results_seen   = 0;
  int pushes_done    = 0;
  int pops_done      = 0;
  int pushes_dropped = 0;
  int pops_refused   = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  // Sender burst state
  int burst_left = 0;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic deq_pkg::idx_t slot_after(deq_pkg::idx_t s);
    return (s == deq_pkg::idx_t'(deq_pkg::DEPTH - 1)) ? deq_pkg::idx_t'(0) :
                                                       deq_pkg::idx_t'(s + 1'b1);
  endfunction

  function automatic deq_pkg::idx_t slot_before(deq_pkg::idx_t s);
    return (s == deq_pkg::idx_t'(0)) ? deq_pkg::idx_t'(deq_pkg::DEPTH - 1) :
                                      deq_pkg::idx_t'(s - 1'b1);
  endfunction

  // Apply one command to the shadow deque and return the beat it must produce
  function automatic deq_pkg::deq_out_t apply_command(deq_pkg::deq_in_t cmd);
    deq_pkg::deq_out_t r;
    r = '0;
    case (cmd.mode)
      deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
        if (word_count >= deq_pkg::DEPTH) begin
          r.overflow = 1'b1;
          pushes_dropped++;
        end else begin
          if (cmd.mode == deq_pkg::MODE_PUSH_FRONT) begin
            head_slot = slot_before(head_slot);
            deque_words[head_slot] = deq_pkg::data_t'(cmd.push_value);
          end else begin
            deque_words[tail_slot] = deq_pkg::data_t'(cmd.push_value);
            tail_slot = slot_after(tail_slot);
          end
          word_count++;
          pushes_done++;
        end
      end
      deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
        if (word_count == 0) begin
          r.underflow = 1'b1;
          pops_refused++;
        end else begin
          if (cmd.mode == deq_pkg::MODE_POP_FRONT) begin
            r.popped_value = deq_pkg::VALUE_W'(deque_words[head_slot]);
            head_slot = slot_after(head_slot);
          end else begin
            tail_slot = slot_before(tail_slot);
            r.popped_value = deq_pkg::VALUE_W'(deque_words[tail_slot]);
          end
          word_count--;
          pops_done++;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = deq_pkg::COUNT_W'(word_count);
    r.is_empty    = (word_count == 0);
    if (word_count != 0) begin
      r.front_value = deq_pkg::VALUE_W'(deque_words[head_slot]);
      r.back_value  = deq_pkg::VALUE_W'(deque_words[slot_before(tail_slot)]);
    end
    return r;
  endfunction

  // Mostly random words, with the extremes mixed in
  function automatic logic [deq_pkg::VALUE_W-1:0] pick_value();
    logic [deq_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 31))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = 32'hffff_ffff;
      3:       v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Send one command beat; hold valid across bursts, idle between them
  task automatic send_command(input logic [deq_pkg::MODE_W-1:0] op,
                              input logic [deq_pkg::VALUE_W-1:0] value);
    deq_pkg::deq_in_t  cmd;
    deq_pkg::deq_out_t predicted;
    int                idle_ticks;
    cmd.mode       = op;
    cmd.push_value = value;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle_ticks = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle_ticks > 0) begin
        in_valid <= 1'b0;
        repeat (idle_ticks) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    predicted = apply_command(cmd);
    awaited_results.insert(awaited_results.size(), predicted);
    commands_sent++;
  endtask

  // Hold off the sender until every awaited beat has arrived
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Receiver stall pattern: free flow, coin flips, a regular hole, rare stalls
  logic [15:0] rx_tick = '0;
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    case (rx_tick[8:7])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 1) == 0);
      2'd2:    out_ready <= (rx_tick[2:0] != 3'd0);
      default: out_ready <= ($urandom_range(0, 7) > 1);
    endcase
  end

  task automatic check_field(input string name, input logic [deq_pkg::VALUE_W-1:0] want,
                             input logic [deq_pkg::VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    deq_pkg::deq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with no command awaiting one: %h", out_data);
        mismatches++;
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        check_field("popped_value", want.popped_value, out_data.popped_value);
        check_field("underflow", deq_pkg::VALUE_W'(want.underflow),
                    deq_pkg::VALUE_W'(out_data.underflow));
        check_field("overflow", deq_pkg::VALUE_W'(want.overflow),
                    deq_pkg::VALUE_W'(out_data.overflow));
        check_field("entry_count", deq_pkg::VALUE_W'(want.entry_count),
                    deq_pkg::VALUE_W'(out_data.entry_count));
        check_field("is_empty", deq_pkg::VALUE_W'(want.is_empty),
                    deq_pkg::VALUE_W'(out_data.is_empty));
        check_field("front_value",  want.front_value,  out_data.front_value);
        check_field("back_value",   want.back_value,   out_data.back_value);
        results_seen++;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d beats outstanding",
             cycle_count, awaited_results.size());
    $display("** double_ended_queue: FAILED **");
    $finish;
  end

  // Pops and queries on an empty deque, then the spare codes
  task automatic test_empty_deque();
    send_command(deq_pkg::MODE_POP_FRONT, 32'h1234_5678);
    send_command(deq_pkg::MODE_POP_BACK,  32'hffff_ffff);
    send_command(deq_pkg::MODE_QUERY,     32'h8000_0000);
    for (int m = int'(MODE_UNUSED_FIRST); m <= int'(MODE_UNUSED_LAST); m++) begin
      send_command(deq_pkg::MODE_W'(m), 32'h7fff_ffff);
    end
  endtask

  // Extreme values through one to three entries at each end
  task automatic test_extreme_values();
    send_command(deq_pkg::MODE_PUSH_FRONT, 32'h7fff_ffff);
    send_command(deq_pkg::MODE_POP_BACK,   32'h0000_0000);
    send_command(deq_pkg::MODE_PUSH_BACK,  32'h8000_0000);
    send_command(deq_pkg::MODE_POP_FRONT,  32'hffff_ffff);
    send_command(deq_pkg::MODE_PUSH_FRONT, 32'hffff_ffff);
    send_command(deq_pkg::MODE_PUSH_BACK,  32'h0000_0000);
    send_command(deq_pkg::MODE_QUERY,      32'h5555_aaaa);
    send_command(MODE_UNUSED_FIRST,        32'haaaa_5555);
    send_command(deq_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
    send_command(deq_pkg::MODE_POP_BACK,   32'h0000_0001);
    send_command(deq_pkg::MODE_POP_FRONT,  32'h0000_0002);
    send_command(deq_pkg::MODE_POP_FRONT,  32'h0000_0003);
    send_command(deq_pkg::MODE_POP_BACK,   32'h0000_0004);
    send_command(deq_pkg::MODE_PUSH_BACK,  32'h7fff_ffff);
    send_command(deq_pkg::MODE_POP_FRONT,  32'h0000_0005);
  endtask

  // Fill to full from both ends, push into the full deque, then drain a quarter
  task automatic test_fill_and_drain();
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      send_command((i % 2 == 0) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK,
                   pick_value());
    end
    send_command(deq_pkg::MODE_PUSH_FRONT, 32'h7fff_ffff);
    send_command(deq_pkg::MODE_PUSH_BACK,  32'h8000_0000);
    send_command(deq_pkg::MODE_QUERY,      32'h0000_0000);
    send_command(deq_pkg::MODE_POP_FRONT,  32'h0000_0000);
    send_command(deq_pkg::MODE_PUSH_BACK,  32'hffff_ffff);
    send_command(deq_pkg::MODE_PUSH_FRONT, 32'h0000_0000);
    for (int i = 0; i < deq_pkg::DEPTH / 4; i++) begin
      send_command(($urandom_range(0, 1) == 0) ? deq_pkg::MODE_POP_FRONT :
                                                 deq_pkg::MODE_POP_BACK, pick_value());
    end
  endtask

  // Random traffic in phases, each with its own push/pop balance
  task automatic test_random_traffic(input int n_items);
    int                         push_cut;
    int                         roll;
    logic [deq_pkg::MODE_W-1:0] op;
    push_cut = 8;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        push_cut = $urandom_range(4, 12);
      end
      if (i % 150 == 149) begin
        wait_drained();
      end
      roll = $urandom_range(0, 15);
      if (roll == 0) begin
        op = deq_pkg::MODE_W'($urandom_range(deq_pkg::MODE_PUSH_FRONT, MODE_UNUSED_LAST));
      end else if (roll <= push_cut) begin
        op = ($urandom_range(0, 1) == 0) ? deq_pkg::MODE_PUSH_FRONT :
                                           deq_pkg::MODE_PUSH_BACK;
      end else begin
        op = ($urandom_range(0, 1) == 0) ? deq_pkg::MODE_POP_FRONT :
                                           deq_pkg::MODE_POP_BACK;
      end
      send_command(op, pick_value());
    end
  endtask

  // Sequence the tests
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_deque();
    test_extreme_values();
    wait_drained();
    test_fill_and_drain();
    wait_drained();
    test_random_traffic(300);

    wait_drained();
    $display("%0d commands sent, %0d result beats checked; %0d pushes and %0d pops took effect.",
             commands_sent, results_seen, pushes_done, pops_done);
    $display("%0d pushes dropped on a full deque of %0d, %0d pops refused on an empty one.",
             pushes_dropped, deq_pkg::DEPTH, pops_refused);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("** double_ended_queue: PASSED **");
    end else begin
      $display("** double_ended_queue: FAILED **");
    end
    $finish;
  end

endmodule

>>> double_ended_queue.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
